// ===== rtl/crc32_engine_with_combine_top_macros.svh =====
// assertion macros for the crc32 engine with combine
`ifndef CRC32_ENGINE_WITH_COMBINE_TOP_MACROS_SVH
`define CRC32_ENGINE_WITH_COMBINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is low
`define CRC32EC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define CRC32EC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRC32EC_ASSERT(name, prop, msg)
`define CRC32EC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/crc32ec_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32ec_pkg
// shared types, codes and gf(2) helpers for the crc32 engine with combine
// ----------------------------------------------------------------------------
`default_nettype none

package crc32ec_pkg;

  localparam int unsigned WORD_BYTES = 8;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [1:0] KIND_MSG    = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_SHIFT  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first;
    logic        last;
    logic [31:0] crc_in;
    logic [31:0] factor;
    logic [31:0] shift_bits;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  source;
  } out_item_t;

  typedef enum logic [1:0] {
    SEL_MSG   = 2'd0,
    SEL_MUL   = 2'd1,
    SEL_SHIFT = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     msg_en;
    logic     shift_start;
    logic     shift_step;
    logic     out_load;
    out_sel_t out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic shift_last;
  } dp_status_t;

  typedef logic [31:0] pow_tab_t [32];

  // reflected carry-less product modulo the polynomial
  function automatic logic [31:0] gf_mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] p;
    logic [31:0] bb;
    p  = '0;
    bb = b;
    for (int i = 31; i >= 0; i--) begin
      if (a[i]) p = p ^ bb;
      bb = bb[0] ? ((bb >> 1) ^ CRC_POLY) : (bb >> 1);
    end
    return p;
  endfunction

  // entry k is x^(2^k) mod P, reflected
  function automatic pow_tab_t gen_pow_table();
    pow_tab_t t;
    t[0] = 32'h40000000;
    for (int k = 1; k < 32; k++) t[k] = gf_mul(t[k-1], t[k-1]);
    return t;
  endfunction

  localparam pow_tab_t POW_TABLE = gen_pow_table();

  // run the valid bytes of one word through the crc, first byte in the low bits
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [63:0] data,
                                           input logic [3:0] count);
    logic [31:0] c;
    logic [3:0]  n;
    c = crc;
    n = (count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : count;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (4'(i) < n) begin
        c = c ^ {24'd0, data[8*i +: 8]};
        for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32_engine_with_combine_top.sv =====
// ----------------------------------------------------------------------------
// crc32_engine_with_combine_top
// crc-32 (reflected 0xEDB88320) with gf multiply and shift for crc combining
// ----------------------------------------------------------------------------
// usage: items enter on in_valid/in_ready, results leave on out_valid/out_ready.
// kind 0 message words stream one beat per cycle while in_ready is high;
// a word with last set puts the inverted crc into the output register
// in the cycle after accept. kind 1 multiply gives its product in the
// cycle after accept. kind 2 shift holds the input through the S_SHIFT and
// S_DONE states: 32 steps of a gf multiplier, one per bit of shift_bits
// against a constant power table, then one load of the result in S_DONE
// once the output register is free. the output register lets the next beat
// enter while a result waits, as long as out_ready is high or the register
// is empty; a stalled receiver holds in_ready low while a result waits.
// kind 3 beats are taken and dropped.
// reset clears the running crc to zero and empties the output register;
// no warm-up pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_engine_with_combine_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire crc32ec_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output crc32ec_pkg::out_item_t out_data
);

  crc32ec_pkg::ctrl_cmd_t  cmd;
  crc32ec_pkg::dp_status_t status;

  crc32ec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_data.kind),
    .in_last   (in_data.last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  crc32ec_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/crc32ec_datapath.sv =====
// ----------------------------------------------------------------------------
// crc32ec_datapath
// running crc, combinational multiplier, iterative shift and result register
// ----------------------------------------------------------------------------
`default_nettype none

module crc32ec_datapath (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire crc32ec_pkg::in_item_t  in_data,
  input  wire crc32ec_pkg::ctrl_cmd_t cmd,
  output crc32ec_pkg::dp_status_t status,
  output crc32ec_pkg::out_item_t   out_data
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] n_r;
  logic [4:0]  k_r, k_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  src_r, src_nxt;
  logic [31:0] crc_base;
  logic [31:0] acc_prod;

  assign crc_base = in_data.first ? ~in_data.crc_in : crc_r;
  assign crc_nxt  = cmd.msg_en ? crc32ec_pkg::crc_word(crc_base, in_data.data_word,
                                                       in_data.byte_count) : crc_r;
  assign acc_prod = crc32ec_pkg::gf_mul(acc_r, crc32ec_pkg::POW_TABLE[k_r]);

  always_comb begin
    acc_nxt = acc_r;
    k_nxt   = k_r;
    if (cmd.shift_start) begin
      acc_nxt = in_data.crc_in;
      k_nxt   = '0;
    end else if (cmd.shift_step) begin
      if (n_r[k_r]) acc_nxt = acc_prod;
      k_nxt = k_r + 5'd1;
    end
  end

  always_comb begin
    res_nxt = res_r;
    src_nxt = src_r;
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        crc32ec_pkg::SEL_MSG: begin
          res_nxt = ~crc_nxt;
          src_nxt = crc32ec_pkg::KIND_MSG;
        end
        crc32ec_pkg::SEL_MUL: begin
          res_nxt = crc32ec_pkg::gf_mul(in_data.crc_in, in_data.factor);
          src_nxt = crc32ec_pkg::KIND_MUL;
        end
        crc32ec_pkg::SEL_SHIFT: begin
          res_nxt = acc_r;
          src_nxt = crc32ec_pkg::KIND_SHIFT;
        end
        default: begin
          res_nxt = res_r;
          src_nxt = src_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      k_r   <= '0;
    end else begin
      crc_r <= crc_nxt;
      k_r   <= k_nxt;
    end
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    src_r <= src_nxt;
    if (cmd.shift_start) n_r <= in_data.shift_bits;
  end

  assign status.shift_last = (k_r == 5'd31);
  assign out_data.result   = res_r;
  assign out_data.source   = src_r;

endmodule

`default_nettype wire

// ===== rtl/crc32ec_ctrl.sv =====
// ----------------------------------------------------------------------------
// crc32ec_ctrl
// handshake and sequencing for message, multiply and shift items
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_engine_with_combine_top_macros.svh"

module crc32ec_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [1:0]               in_kind,
  input  wire                      in_last,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  wire crc32ec_pkg::dp_status_t status,
  output crc32ec_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    cmd.msg_en      = 1'b0;
    cmd.shift_start = 1'b0;
    cmd.shift_step  = 1'b0;
    cmd.out_load    = 1'b0;
    cmd.out_sel     = crc32ec_pkg::SEL_MSG;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            crc32ec_pkg::KIND_MSG: begin
              cmd.msg_en   = 1'b1;
              cmd.out_load = in_last;
            end
            crc32ec_pkg::KIND_MUL: begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = crc32ec_pkg::SEL_MUL;
            end
            crc32ec_pkg::KIND_SHIFT: begin
              cmd.shift_start = 1'b1;
              state_nxt       = S_SHIFT;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (status.shift_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.out_sel = crc32ec_pkg::SEL_SHIFT;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CRC32EC_ASSERT(a_shift_blocks,
    in_fire && in_kind == crc32ec_pkg::KIND_SHIFT |=> !in_ready,
    "shift item did not block input")
  `CRC32EC_ASSERT(a_shift_ends,
    state_r == S_SHIFT && status.shift_last |=> state_r == S_DONE,
    "shift sweep did not end")
  `CRC32EC_ASSERT(a_no_overwrite, cmd.out_load |-> out_free, "result register overwritten")
  `CRC32EC_ASSERT_ALWAYS(a_reset_idle,
    !rst_n |=> !out_valid_r && state_r == S_IDLE,
    "reset left block busy")

endmodule

`default_nettype wire
